// File: sv/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Types and encoding constants shared by the PC-relative decoder pipeline.
// ----------------------------------------------------------------------------
package prd_pkg;

   // Instruction class reported on the result channel
   typedef enum logic [3:0] {
      KIND_NONE   = 4'd0,
      KIND_B      = 4'd1,
      KIND_BL     = 4'd2,
      KIND_BCOND  = 4'd3,
      KIND_BCCOND = 4'd4,
      KIND_ADR    = 4'd5,
      KIND_ADRP   = 4'd6,
      KIND_LDRLIT = 4'd7,
      KIND_CBZ    = 4'd8,
      KIND_CBNZ   = 4'd9,
      KIND_TBZ    = 4'd10,
      KIND_TBNZ   = 4'd11
   } kind_type;

   // Opcode masks and match values
   localparam logic [31:0] MASK_BRANCH   = 32'hfc00_0000;
   localparam logic [31:0] MATCH_B       = 32'h1400_0000;
   localparam logic [31:0] MATCH_BL      = 32'h9400_0000;
   localparam logic [31:0] MASK_BCOND    = 32'hff00_0000;
   localparam logic [31:0] MATCH_BCOND   = 32'h5400_0000;
   localparam logic [31:0] MASK_ADR      = 32'h9f00_0000;
   localparam logic [31:0] MATCH_ADRP    = 32'h9000_0000;
   localparam logic [31:0] MATCH_ADR     = 32'h1000_0000;
   localparam logic [31:0] MASK_LDRLIT   = 32'hbf00_0000;
   localparam logic [31:0] MATCH_LDRLIT  = 32'h1800_0000;
   localparam logic [31:0] MASK_CMPTEST  = 32'h7e00_0000;
   localparam logic [31:0] MATCH_CBZ     = 32'h3400_0000;
   localparam logic [31:0] MATCH_TBZ     = 32'h3600_0000;

   // Side fields that travel with an item down the pipeline
   typedef struct packed {
      kind_type    kind;
      logic [4:0]  reg_number;
      logic        reg_is_64;
      logic [3:0]  cond_code;
      logic [5:0]  test_bit;
   } info_type;

endpackage

// File: sv/prd_decode.sv
// ----------------------------------------------------------------------------
// prd_decode
// Classifies one instruction word and forms the add operands and side fields.
// ----------------------------------------------------------------------------
module prd_decode
   import prd_pkg::*;
(
   input  logic [31:0] instr_word,
   input  logic [63:0] pc,
   output info_type    info,
   output logic [63:0] base,
   output logic [63:0] offset
);

   logic [20:0] adr_imm;

   assign adr_imm = {instr_word[23:5], instr_word[30:29]};

   // Decode by priority, matching the class order of the encoding table
   always_comb begin
      info   = '{kind: KIND_NONE, reg_number: 5'd0, reg_is_64: 1'b0,
                 cond_code: 4'd0, test_bit: 6'd0};
      base   = 64'd0;
      offset = 64'd0;
      if (((instr_word & MASK_BRANCH) == MATCH_B) ||
          ((instr_word & MASK_BRANCH) == MATCH_BL)) begin
         info.kind = instr_word[31] ? KIND_BL : KIND_B;
         base      = pc;
         offset    = {{36{instr_word[25]}}, instr_word[25:0], 2'b00};
      end else if ((instr_word & MASK_BCOND) == MATCH_BCOND) begin
         info.kind      = instr_word[4] ? KIND_BCCOND : KIND_BCOND;
         info.cond_code = instr_word[3:0];
         base           = pc;
         offset         = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
      end else if (((instr_word & MASK_ADR) == MATCH_ADRP) ||
                   ((instr_word & MASK_ADR) == MATCH_ADR)) begin
         info.reg_number = instr_word[4:0];
         info.reg_is_64  = 1'b1;
         if (instr_word[31]) begin
            // Page-aligned origin, immediate counts 4 KiB pages
            info.kind = KIND_ADRP;
            base      = {pc[63:12], 12'd0};
            offset    = {{31{adr_imm[20]}}, adr_imm, 12'd0};
         end else begin
            info.kind = KIND_ADR;
            base      = pc;
            offset    = {{43{adr_imm[20]}}, adr_imm};
         end
      end else if ((instr_word & MASK_LDRLIT) == MATCH_LDRLIT) begin
         info.kind       = KIND_LDRLIT;
         info.reg_number = instr_word[4:0];
         info.reg_is_64  = instr_word[30];
         base            = pc;
         offset          = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
      end else if ((instr_word & MASK_CMPTEST) == MATCH_CBZ) begin
         info.kind       = instr_word[24] ? KIND_CBNZ : KIND_CBZ;
         info.reg_number = instr_word[4:0];
         info.reg_is_64  = instr_word[31];
         base            = pc;
         offset          = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
      end else if ((instr_word & MASK_CMPTEST) == MATCH_TBZ) begin
         info.kind       = instr_word[24] ? KIND_TBNZ : KIND_TBZ;
         info.reg_number = instr_word[4:0];
         info.reg_is_64  = instr_word[31];
         info.test_bit   = {instr_word[31], instr_word[23:19]};
         base            = pc;
         offset          = {{48{instr_word[18]}}, instr_word[18:5], 2'b00};
      end
   end

endmodule

// File: sv/prd_add.sv
// ----------------------------------------------------------------------------
// prd_add
// Two-stage 64-bit target adder: low half with carry, then high half.
// ----------------------------------------------------------------------------
module prd_add
   import prd_pkg::*;
(
   input  logic        clock,
   input  logic        load_lo,
   input  logic        load_hi,
   input  logic [63:0] base,
   input  logic [63:0] offset,
   input  info_type    info_in,
   output logic [63:0] target,
   output info_type    info_out
);

   logic [32:0] lo_sum_ff, lo_sum_in;
   logic [31:0] hi_base_ff;
   logic [31:0] hi_off_ff;
   info_type    info_lo_ff;
   logic [63:0] sum_ff, sum_in;
   info_type    info_hi_ff;

   // Add low halves, keep carry
   assign lo_sum_in = {1'b0, base[31:0]} + {1'b0, offset[31:0]};

   always_ff @(posedge clock) begin
      if (load_lo) begin
         lo_sum_ff  <= lo_sum_in;
         hi_base_ff <= base[63:32];
         hi_off_ff  <= offset[63:32];
         info_lo_ff <= info_in;
      end
   end

   // Add high halves with the carry, wrapping modulo 2^64
   assign sum_in = {hi_base_ff + hi_off_ff + {31'd0, lo_sum_ff[32]}, lo_sum_ff[31:0]};

   always_ff @(posedge clock) begin
      if (load_hi) begin
         sum_ff     <= sum_in;
         info_hi_ff <= info_lo_ff;
      end
   end

   assign target   = sum_ff;
   assign info_out = info_hi_ff;

endmodule

// File: sv/pc_relative_instruction_decoder_core.sv
// ----------------------------------------------------------------------------
// pc_relative_instruction_decoder_core
// Decodes AArch64 PC-relative instructions and computes their targets.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one instruction word and its 64-bit address per
//   transfer. Response channel (rsp_*): class, target address, register
//   number and width, condition code and tested bit number of that word.
//   A transfer happens on a rising edge with valid high and stall low.
// Pipeline:
//   Three register stages (decode, low-half add, high-half add); the request
//   is registered in the decode stage, then in the low-half and high-half add
//   stages, and rsp_valid rises once it is in the high-half add stage. One
//   item is accepted every cycle while the response side does not stall.
// Reset:
//   Synchronous, active high; clears all stage valid bits. The pipeline is
//   empty after reset and accepts an item on the next cycle.
// Stall:
//   A stalled response holds in the output stage. Earlier stages keep
//   filling into empty slots; req_stall rises only when all stages are full
//   and the receiver stalls.
// ----------------------------------------------------------------------------
module pc_relative_instruction_decoder_core
   import prd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   input  logic [63:0] req_pc,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_instr_kind,
   output logic [63:0] rsp_target_address,
   output logic [4:0]  rsp_reg_number,
   output logic        rsp_reg_is_64,
   output logic [3:0]  rsp_cond_code,
   output logic [5:0]  rsp_test_bit
);

   logic        v1_ff, v2_ff, v3_ff;
   logic        v1_in, v2_in, v3_in;
   logic        en1, en2, en3;
   info_type    dec_info;
   logic [63:0] dec_base, dec_offset;
   info_type    s1_info_ff;
   logic [63:0] s1_base_ff, s1_offset_ff;
   info_type    out_info;
   logic [63:0] out_target;

   // Stage enables: a stage loads when empty or when its content moves on
   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;

   // Advance valid bits with the data
   always_comb begin
      v1_in = en1 ? req_valid : v1_ff;
      v2_in = en2 ? v1_ff     : v2_ff;
      v3_in = en3 ? v2_ff     : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage 1: decode
   prd_decode u_decode (
      .instr_word (req_instr_word),
      .pc         (req_pc),
      .info       (dec_info),
      .base       (dec_base),
      .offset     (dec_offset)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_info_ff   <= dec_info;
         s1_base_ff   <= dec_base;
         s1_offset_ff <= dec_offset;
      end
   end

   // Stages 2 and 3: split target add
   prd_add u_add (
      .clock    (clock),
      .load_lo  (en2),
      .load_hi  (en3),
      .base     (s1_base_ff),
      .offset   (s1_offset_ff),
      .info_in  (s1_info_ff),
      .target   (out_target),
      .info_out (out_info)
   );

   // Drive the response
   assign rsp_valid          = v3_ff;
   assign rsp_instr_kind     = out_info.kind;
   assign rsp_target_address = out_target;
   assign rsp_reg_number     = out_info.reg_number;
   assign rsp_reg_is_64      = out_info.reg_is_64;
   assign rsp_cond_code      = out_info.cond_code;
   assign rsp_test_bit       = out_info.test_bit;

`ifndef SYNTH
   // Back-pressure only when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // Unrecognized words carry all-zero results
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_info.kind == KIND_NONE) |->
         (rsp_target_address == 64'd0 && rsp_reg_number == 5'd0 &&
          !rsp_reg_is_64 && rsp_cond_code == 4'd0 && rsp_test_bit == 6'd0))
      else $error("unrecognized word with nonzero result fields");

   // Test bit only for TBZ/TBNZ
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_info.kind != KIND_TBZ && out_info.kind != KIND_TBNZ) |->
         (rsp_test_bit == 6'd0))
      else $error("test bit set for a non-test branch");

   // Condition code only for conditional branches
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_info.kind != KIND_BCOND && out_info.kind != KIND_BCCOND) |->
         (rsp_cond_code == 4'd0))
      else $error("condition code set for a non-conditional kind");

   // A stalled result stays in the output stage
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && rsp_stall) |=> (v3_ff && $stable(out_target)))
      else $error("stalled result lost or changed");
`endif

endmodule
